// ===== hw/rtl/fprp_pkg.sv =====
package fprp_pkg;

  // parse phases of one message
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_FUNC,
    PH_MARK,
    PH_SUBLEN,
    PH_DWORD,
    PH_PROC,
    PH_SVC,
    PH_S1,
    PH_S2,
    PH_S3,
    PH_BODY,
    PH_TRAIL,
    PH_SKIP
  } fprp_phase_t;

  // function words with a known layout
  localparam logic [15:0] FN_SUPPORTED   = 16'h0000;
  localparam logic [15:0] FN_LISTEN      = 16'h0001;
  localparam logic [15:0] FN_HOLD        = 16'h0004;
  localparam logic [15:0] FN_RETRIEVE    = 16'h0005;
  localparam logic [15:0] FN_CF_ACTIVATE = 16'h0009;
  localparam logic [15:0] FN_CF_DEACT    = 16'h000a;
  localparam logic [15:0] FN_CF_INTERROG = 16'h000b;
  localparam logic [15:0] FN_CF_NUMBERS  = 16'h000c;

  // marker byte for the supported-services layout
  localparam logic [7:0] MARK_BYTE = 8'h00;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_UNKNOWN   = 2'd1;
  localparam logic [1:0] STS_MALFORMED = 2'd2;

  // result beat, last declared field (status) in the lowest bits
  typedef struct packed {
    logic [7:0]  third_struct_length;
    logic [7:0]  third_struct_offset;
    logic [7:0]  second_struct_length;
    logic [7:0]  second_struct_offset;
    logic [7:0]  first_struct_length;
    logic [7:0]  first_struct_offset;
    logic [15:0] basic_service;
    logic [15:0] procedure;
    logic [31:0] dword_value;
    logic [15:0] function_code;
    logic [1:0]  status;
  } fprp_result_t;

  localparam int RES_W       = $bits(fprp_result_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;
  localparam int IN_TDATA_W  = 8;

  // functions whose parameter opens with a sub-structure length
  function automatic logic has_sublen(input logic [15:0] fn);
    return (fn == FN_LISTEN) || (fn == FN_HOLD) || (fn == FN_RETRIEVE) ||
           (fn == FN_CF_ACTIVATE) || (fn == FN_CF_DEACT) ||
           (fn == FN_CF_INTERROG) || (fn == FN_CF_NUMBERS);
  endfunction

  // forwarding functions carrying procedure and basic service words
  function automatic logic is_forward3(input logic [15:0] fn);
    return (fn == FN_CF_ACTIVATE) || (fn == FN_CF_DEACT) || (fn == FN_CF_INTERROG);
  endfunction

  // element that follows a finished element
  function automatic fprp_phase_t next_after(input fprp_phase_t ph, input logic [15:0] fn);
    fprp_phase_t nph;
    case (ph)
      PH_DWORD: nph = is_forward3(fn) ? PH_PROC : PH_TRAIL;
      PH_PROC:  nph = PH_SVC;
      PH_SVC:   nph = PH_S1;
      PH_S1:    nph = (fn == FN_CF_ACTIVATE) ? PH_S2 : PH_TRAIL;
      PH_S2:    nph = PH_S3;
      default:  nph = PH_TRAIL;
    endcase
    return nph;
  endfunction

  // struct slot number back to its length phase
  function automatic fprp_phase_t slot_phase(input logic [1:0] k);
    fprp_phase_t ph;
    case (k)
      2'd0:    ph = PH_S1;
      2'd1:    ph = PH_S2;
      default: ph = PH_S3;
    endcase
    return ph;
  endfunction

  // true when an element starting at nxt does not fit below limit, or for the trailer when nxt is not limit
  function automatic logic enter_fails(input fprp_phase_t ph, input logic [8:0] nxt,
                                       input logic [8:0] limit);
    logic [9:0] need;
    case (ph)
      PH_DWORD:        need = 10'd4;
      PH_PROC, PH_SVC: need = 10'd2;
      default:         need = 10'd1;
    endcase
    if (ph == PH_TRAIL) begin
      return nxt != limit;
    end
    return ({1'b0, nxt} + need) > {1'b0, limit};
  endfunction

endpackage

// ===== hw/rtl/fprp_in_stage.sv =====
module fprp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  logic       vld_r;
  logic [7:0] byte_r;

  // free slot or slot drained this cycle
  assign in_tready  = !vld_r || take;
  assign byte_valid = vld_r;
  assign byte_q     = byte_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // byte holding register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/fprp_parser.sv =====
module fprp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  out_ready,
  output logic                  take,
  output logic                  res_valid,
  output fprp_pkg::fprp_result_t res
);

  fprp_pkg::fprp_phase_t phase_r, phase_nxt, phase_step, enter_tgt;

  logic [8:0]  pos_r, pos_nxt;
  logic [8:0]  msg_end_r, msg_end_nxt;
  logic [8:0]  inner_end_r, inner_end_nxt;
  logic [8:0]  emb_end_r, emb_end_nxt;
  logic [1:0]  fbi_r, fbi_nxt;
  logic        mal_r, mal_nxt;
  logic [15:0] func_r, func_nxt;
  logic [31:0] dword_r, dword_nxt;
  logic [15:0] proc_r, proc_nxt;
  logic [15:0] svc_r, svc_nxt;
  logic [7:0]  soff_r [3];
  logic [7:0]  soff_nxt [3];
  logic [7:0]  slen_r [3];
  logic [7:0]  slen_nxt [3];

  logic [8:0]  nxt;
  logic [9:0]  sub_sum;
  logic [15:0] func_word;
  logic [1:0]  slot_k;
  logic [8:0]  enter_lim;
  logic        do_enter;
  logic        fail_now;
  logic        idle;
  logic        msg_done;
  logic        res_mal;

  assign take      = in_valid && out_ready;
  assign idle      = (phase_r == fprp_pkg::PH_IDLE);
  assign nxt       = pos_r + 9'd1;
  assign sub_sum   = {1'b0, nxt} + {2'b00, in_byte};
  assign func_word = fbi_r[0] ? {in_byte, func_r[7:0]} : {8'h00, in_byte};
  assign msg_done  = !idle && (nxt >= msg_end_r);

  // slot number of the current struct length phase
  always_comb begin
    case (phase_r)
      fprp_pkg::PH_S1: slot_k = 2'd0;
      fprp_pkg::PH_S2: slot_k = 2'd1;
      default:         slot_k = 2'd2;
    endcase
  end

  // next phase of the layout walk
  always_comb begin
    phase_step = phase_r;
    fail_now   = 1'b0;
    do_enter   = 1'b0;
    enter_tgt  = fprp_pkg::PH_TRAIL;
    enter_lim  = inner_end_r;
    unique case (phase_r)
      fprp_pkg::PH_IDLE: begin
        phase_step = (in_byte == 8'h00) ? fprp_pkg::PH_IDLE : fprp_pkg::PH_FUNC;
      end
      fprp_pkg::PH_FUNC: begin
        if (fbi_r[0]) begin
          if (func_word == fprp_pkg::FN_SUPPORTED) begin
            phase_step = fprp_pkg::PH_MARK;
          end else if (fprp_pkg::has_sublen(func_word)) begin
            phase_step = fprp_pkg::PH_SUBLEN;
          end else begin
            phase_step = fprp_pkg::PH_SKIP;
          end
        end
      end
      fprp_pkg::PH_MARK: begin
        if (in_byte != fprp_pkg::MARK_BYTE) begin
          fail_now = 1'b1;
        end else begin
          do_enter  = 1'b1;
          enter_tgt = fprp_pkg::PH_TRAIL;
        end
      end
      fprp_pkg::PH_SUBLEN: begin
        if (sub_sum > {1'b0, msg_end_r}) begin
          fail_now = 1'b1;
        end else begin
          do_enter  = 1'b1;
          enter_lim = sub_sum[8:0];
          enter_tgt = ((func_r == fprp_pkg::FN_HOLD) || (func_r == fprp_pkg::FN_RETRIEVE)) ?
                      fprp_pkg::PH_S1 : fprp_pkg::PH_DWORD;
        end
      end
      fprp_pkg::PH_DWORD: begin
        if (fbi_r == 2'd3) begin
          do_enter  = 1'b1;
          enter_tgt = fprp_pkg::next_after(fprp_pkg::PH_DWORD, func_r);
        end
      end
      fprp_pkg::PH_PROC, fprp_pkg::PH_SVC: begin
        if (fbi_r[0]) begin
          do_enter  = 1'b1;
          enter_tgt = fprp_pkg::next_after(phase_r, func_r);
        end
      end
      fprp_pkg::PH_S1, fprp_pkg::PH_S2, fprp_pkg::PH_S3: begin
        if (sub_sum > {1'b0, inner_end_r}) begin
          fail_now = 1'b1;
        end else if (in_byte == 8'h00) begin
          do_enter  = 1'b1;
          enter_tgt = fprp_pkg::next_after(phase_r, func_r);
        end else begin
          phase_step = fprp_pkg::PH_BODY;
        end
      end
      fprp_pkg::PH_BODY: begin
        if (nxt == emb_end_r) begin
          do_enter  = 1'b1;
          enter_tgt = fprp_pkg::next_after(fprp_pkg::slot_phase(fbi_r), func_r);
        end
      end
      fprp_pkg::PH_TRAIL: begin
        fail_now = 1'b1;
      end
      fprp_pkg::PH_SKIP: begin
        phase_step = fprp_pkg::PH_SKIP;
      end
      default: begin
        phase_step = fprp_pkg::PH_IDLE;
      end
    endcase
    if (do_enter) begin
      if (fprp_pkg::enter_fails(enter_tgt, nxt, enter_lim)) begin
        fail_now = 1'b1;
      end else begin
        phase_step = enter_tgt;
      end
    end
    if (fail_now) begin
      phase_step = fprp_pkg::PH_SKIP;
    end
    phase_nxt = msg_done ? fprp_pkg::PH_IDLE : phase_step;
  end

  // field assembly and result
  always_comb begin
    pos_nxt       = nxt;
    msg_end_nxt   = msg_end_r;
    inner_end_nxt = inner_end_r;
    emb_end_nxt   = emb_end_r;
    fbi_nxt       = fbi_r;
    mal_nxt       = mal_r | fail_now;
    func_nxt      = func_r;
    dword_nxt     = dword_r;
    proc_nxt      = proc_r;
    svc_nxt       = svc_r;
    soff_nxt      = soff_r;
    slen_nxt      = slen_r;
    if (idle) begin
      // length byte opens a new message
      pos_nxt       = 9'd1;
      msg_end_nxt   = {1'b0, in_byte} + 9'd1;
      inner_end_nxt = '0;
      emb_end_nxt   = '0;
      fbi_nxt       = '0;
      mal_nxt       = 1'b0;
      func_nxt      = '0;
      dword_nxt     = '0;
      proc_nxt      = '0;
      svc_nxt       = '0;
      soff_nxt      = '{default: '0};
      slen_nxt      = '{default: '0};
    end else begin
      case (phase_r)
        fprp_pkg::PH_FUNC: begin
          func_nxt = func_word;
          fbi_nxt  = {1'b0, ~fbi_r[0]};
          if (fbi_r[0]) begin
            inner_end_nxt = msg_end_r;
          end
        end
        fprp_pkg::PH_MARK: begin
          fbi_nxt = '0;
        end
        fprp_pkg::PH_SUBLEN: begin
          inner_end_nxt = sub_sum[8:0];
          fbi_nxt       = '0;
        end
        fprp_pkg::PH_DWORD: begin
          dword_nxt[{fbi_r, 3'b000} +: 8] = dword_r[{fbi_r, 3'b000} +: 8] | in_byte;
          fbi_nxt = fbi_r + 2'd1;
        end
        fprp_pkg::PH_PROC: begin
          proc_nxt[{fbi_r[0], 3'b000} +: 8] = proc_r[{fbi_r[0], 3'b000} +: 8] | in_byte;
          fbi_nxt = {1'b0, ~fbi_r[0]};
        end
        fprp_pkg::PH_SVC: begin
          svc_nxt[{fbi_r[0], 3'b000} +: 8] = svc_r[{fbi_r[0], 3'b000} +: 8] | in_byte;
          fbi_nxt = {1'b0, ~fbi_r[0]};
        end
        fprp_pkg::PH_S1, fprp_pkg::PH_S2, fprp_pkg::PH_S3: begin
          soff_nxt[slot_k] = pos_r[7:0];
          slen_nxt[slot_k] = in_byte;
          emb_end_nxt      = sub_sum[8:0];
          fbi_nxt          = (in_byte == 8'h00) ? 2'd0 : slot_k;
        end
        fprp_pkg::PH_BODY: begin
          if (nxt == emb_end_r) begin
            fbi_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result beat on the last byte of a message or on a zero length
  always_comb begin
    res_mal   = mal_r | fail_now |
                ((phase_step != fprp_pkg::PH_TRAIL) && (phase_step != fprp_pkg::PH_SKIP));
    res       = '0;
    res_valid = 1'b0;
    if (idle) begin
      res_valid  = (in_byte == 8'h00);
      res.status = fprp_pkg::STS_MALFORMED;
    end else begin
      res_valid         = msg_done;
      res.function_code = func_nxt;
      if (res_mal) begin
        res.status = fprp_pkg::STS_MALFORMED;
      end else if (phase_step == fprp_pkg::PH_SKIP) begin
        res.status = fprp_pkg::STS_UNKNOWN;
      end else begin
        res.status               = fprp_pkg::STS_OK;
        res.dword_value          = dword_nxt;
        res.procedure            = proc_nxt;
        res.basic_service        = svc_nxt;
        res.first_struct_offset  = soff_nxt[0];
        res.first_struct_length  = slen_nxt[0];
        res.second_struct_offset = soff_nxt[1];
        res.second_struct_length = slen_nxt[1];
        res.third_struct_offset  = soff_nxt[2];
        res.third_struct_length  = slen_nxt[2];
      end
    end
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fprp_pkg::PH_IDLE;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  // message state, set up for a new message whenever a length byte is taken
  always_ff @(posedge clk) begin
    if (take) begin
      pos_r       <= pos_nxt;
      msg_end_r   <= msg_end_nxt;
      inner_end_r <= inner_end_nxt;
      emb_end_r   <= emb_end_nxt;
      fbi_r       <= fbi_nxt;
      mal_r       <= mal_nxt;
      func_r      <= func_nxt;
      dword_r     <= dword_nxt;
      proc_r      <= proc_nxt;
      svc_r       <= svc_nxt;
      soff_r      <= soff_nxt;
      slen_r      <= slen_nxt;
    end
  end

endmodule

// ===== hw/rtl/fprp_out_stage.sv =====
module fprp_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         res_valid,
  input  fprp_pkg::fprp_result_t       res,
  output logic                         out_ready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [fprp_pkg::RES_W-1:0]   out_res
);

  logic                   vld_r;
  fprp_pkg::fprp_result_t res_r;

  // room when empty or drained this cycle
  assign out_ready  = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_res    = res_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take && res_valid) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== hw/rtl/facility_request_param_parser_unit.sv =====
// Facility request parameter checker. A message arrives as one byte per
// input beat: a length byte L, then L bytes holding the little-endian
// function word and the layout for that function. On the beat carrying the
// last byte (or on a zero length byte) one result beat follows, giving the
// status (well formed, unknown function skipped, malformed), the function
// word, the dword/procedure/service fields and the offset and length of up
// to three embedded structs. One byte is taken every clock; a byte goes
// through an input register and a single step of the field state machine
// into the result register, so a result beat is driven straight from a register.
// Output backpressure stalls the byte stream only while the result register
// holds a beat that is not taken.
module facility_request_param_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // data_byte [7:0]
  input  logic [fprp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status [1:0], function_code [17:2], dword_value [49:18], procedure [65:50],
  // basic_service [81:66], first_struct_offset [89:82], first_struct_length [97:90],
  // second_struct_offset [105:98], second_struct_length [113:106],
  // third_struct_offset [121:114], third_struct_length [129:122], zero [135:130]
  output logic [fprp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                         take;
  logic                         byte_valid;
  logic [7:0]                   byte_q;
  logic                         out_ready;
  logic                         res_valid;
  fprp_pkg::fprp_result_t       res;
  logic [fprp_pkg::RES_W-1:0]   out_res;

  fprp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  fprp_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_valid),
    .in_byte   (byte_q),
    .out_ready (out_ready),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  fprp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .out_ready  (out_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // pad result to whole bytes
  assign out_tdata = {{fprp_pkg::OUT_PAD_W{1'b0}}, out_res};

endmodule

// ===== hw/rtl/fprp_checker.sv =====
module fprp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [fprp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  fprp_pkg::fprp_result_t r;
  assign r = out_tdata[fprp_pkg::RES_W-1:0];

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // status code is one of the three defined values
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (r.status == fprp_pkg::STS_OK) || (r.status == fprp_pkg::STS_UNKNOWN) ||
                   (r.status == fprp_pkg::STS_MALFORMED))
    else $error("undefined status code");

  // only a well formed result carries numeric and struct fields
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.status != fprp_pkg::STS_OK |->
      r.dword_value == '0 && r.procedure == '0 && r.basic_service == '0 &&
      r.first_struct_length == '0 && r.second_struct_length == '0 &&
      r.third_struct_length == '0)
    else $error("fields set on a malformed or skipped result");

  // input side never stalls while the result register is empty
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule

bind facility_request_param_parser_unit fprp_checker u_fprp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
